@@ rtl/fqs_pkg.sv @@
// ============================================================================
// fqs_pkg
// Shared types, codes and constants of the fifo queue with membership search.
// ============================================================================
`default_nettype none

package fqs_pkg;

    // default number of queue entries
    localparam int FQS_DEPTH      = 16;
    // entries of the command queue between front and back
    localparam int FQS_CMDQ_DEPTH = 2;

    typedef logic        [2:0]  t_action;
    typedef logic signed [31:0] t_data;
    typedef logic        [4:0]  t_count;

    // request action codes
    localparam t_action ACT_PUSH   = 3'd0;
    localparam t_action ACT_POP    = 3'd1;
    localparam t_action ACT_SEARCH = 3'd2;
    localparam t_action ACT_SHOW   = 3'd3;
    localparam t_action ACT_CLEAR  = 3'd4;
    localparam t_action ACT_QUERY  = 3'd5;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_PUSH,
        OP_POP,
        OP_SEARCH,
        OP_SHOW,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op   op;
        t_data operand;
    } t_cmd;

    // one result as held in the output register
    typedef struct packed {
        t_status status;
        t_data   value;
        logic    found;
        logic    is_empty;
        t_count  count;
        logic    last;
    } t_res;

    // back engine states
    typedef enum logic [2:0] {
        BS_IDLE,
        BS_POP,
        BS_SEARCH,
        BS_SRES,
        BS_SHOW
    } t_bstate;

    // map a raw action to an operation; query and unused codes do nothing
    function automatic t_op fqs_decode(input t_action action);
        t_op op;
        unique case (action)
            ACT_PUSH:   op = OP_PUSH;
            ACT_POP:    op = OP_POP;
            ACT_SEARCH: op = OP_SEARCH;
            ACT_SHOW:   op = OP_SHOW;
            ACT_CLEAR:  op = OP_CLEAR;
            ACT_QUERY:  op = OP_NOP;
            default:    op = OP_NOP;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

@@ rtl/fqs_if.sv @@
// ============================================================================
// fqs_if
// Valid/ready channels of the queue: request channel and result channel.
// ============================================================================
`default_nettype none

interface fqs_in_if;
    logic            valid;
    logic            ready;
    fqs_pkg::t_action action;
    fqs_pkg::t_data   operand_value;

    modport source (output valid, output action, output operand_value, input ready);
    modport sink   (input valid, input action, input operand_value, output ready);
endinterface

interface fqs_out_if;
    logic            valid;
    logic            ready;
    logic [1:0]      status;
    fqs_pkg::t_data  result_value;
    logic            found;
    logic            is_empty;
    fqs_pkg::t_count entry_count;
    logic            last_result;

    modport source (output valid, output status, output result_value, output found,
                    output is_empty, output entry_count, output last_result,
                    input ready);
    modport sink   (input valid, input status, input result_value, input found,
                    input is_empty, input entry_count, input last_result,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/fqs_front.sv @@
// ============================================================================
// fqs_front
// Accepts requests, classifies the action and buffers them in a short queue.
// ============================================================================
`default_nettype none

module fqs_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    fqs_in_if.sink          i_cmd,
    output logic            o_cmd_valid,
    output fqs_pkg::t_cmd   o_cmd,
    input  wire             i_cmd_take
);

    localparam int QD  = fqs_pkg::FQS_CMDQ_DEPTH;
    localparam int QAW = $clog2(QD);
    localparam int QCW = $clog2(QD + 1);

    fqs_pkg::t_cmd  r_q [QD];
    logic [QAW-1:0] r_wp, n_wp;
    logic [QAW-1:0] r_rp, n_rp;
    logic [QCW-1:0] r_cnt, n_cnt;
    logic           push, pop;

    function automatic logic [QAW-1:0] q_next(input logic [QAW-1:0] p);
        return (p == QAW'(QD - 1)) ? '0 : p + QAW'(1);
    endfunction

    // handshake and queue bookkeeping
    assign i_cmd.ready = (r_cnt != QCW'(QD));
    assign push        = i_cmd.valid && i_cmd.ready;
    assign pop         = i_cmd_take && (r_cnt != '0);
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_wp  = push ? q_next(r_wp) : r_wp;
        n_rp  = pop ? q_next(r_rp) : r_rp;
        n_cnt = r_cnt + QCW'(push) - QCW'(pop);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // classified request storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{op: fqs_pkg::fqs_decode(i_cmd.action),
                           operand: i_cmd.operand_value};
        end
    end

    // queue fill never passes its depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCW'(QD))
        else $error("command queue overfilled");

endmodule

`default_nettype wire

@@ rtl/fqs_back.sv @@
// ============================================================================
// fqs_back
// Executes classified requests on the ring store and drives the result register.
// ============================================================================
`default_nettype none

module fqs_back #(
    parameter int DEPTH = fqs_pkg::FQS_DEPTH
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_cmd_valid,
    input  fqs_pkg::t_cmd   i_cmd,
    output logic            o_cmd_take,
    fqs_out_if.source       o_res
);

    localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PW1 = PW + 1;

    // ring store, read data registered
    fqs_pkg::t_data r_mem [DEPTH];
    fqs_pkg::t_data r_rd_data;

    fqs_pkg::t_bstate r_state, n_state;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_scan_ptr, n_scan_ptr;
    logic [CW-1:0]    r_occ, n_occ;
    logic [CW-1:0]    r_idx, n_idx;
    logic             r_hit, n_hit;
    fqs_pkg::t_data   r_probe, n_probe;
    logic             r_out_valid, n_out_valid;
    fqs_pkg::t_res    r_out, n_out;

    logic             slot_free;
    logic             mem_we, mem_re;
    logic [PW-1:0]    mem_raddr;
    logic             emit;
    fqs_pkg::t_status emit_status;
    fqs_pkg::t_data   emit_value;
    logic             emit_found, emit_last;
    logic             show_last;

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign slot_free = !r_out_valid || o_res.ready;
    assign show_last = (r_idx == r_occ - CW'(1));

    // request execution and result generation
    always_comb begin
        n_state     = r_state;
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_scan_ptr  = r_scan_ptr;
        n_occ       = r_occ;
        n_idx       = r_idx;
        n_hit       = r_hit;
        n_probe     = r_probe;
        o_cmd_take  = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_raddr   = r_rd_ptr;
        emit        = 1'b0;
        emit_status = fqs_pkg::ST_OK;
        emit_value  = '0;
        emit_found  = 1'b0;
        emit_last   = 1'b1;

        unique case (r_state)
            fqs_pkg::BS_IDLE: begin
                if (i_cmd_valid && slot_free) begin
                    o_cmd_take = 1'b1;
                    unique case (i_cmd.op)
                        fqs_pkg::OP_PUSH: begin
                            emit = 1'b1;
                            if (r_occ == CW'(DEPTH)) begin
                                emit_status = fqs_pkg::ST_FULL;
                            end else begin
                                mem_we   = 1'b1;
                                n_wr_ptr = ptr_next(r_wr_ptr);
                                n_occ    = r_occ + CW'(1);
                            end
                        end
                        fqs_pkg::OP_POP: begin
                            if (r_occ == '0) begin
                                emit        = 1'b1;
                                emit_status = fqs_pkg::ST_EMPTY;
                            end else begin
                                mem_re  = 1'b1;
                                n_state = fqs_pkg::BS_POP;
                            end
                        end
                        fqs_pkg::OP_SEARCH: begin
                            if (r_occ == '0) begin
                                emit = 1'b1;
                            end else begin
                                mem_re     = 1'b1;
                                n_scan_ptr = ptr_next(r_rd_ptr);
                                n_idx      = '0;
                                n_hit      = 1'b0;
                                n_probe    = i_cmd.operand;
                                n_state    = fqs_pkg::BS_SEARCH;
                            end
                        end
                        fqs_pkg::OP_SHOW: begin
                            if (r_occ == '0) begin
                                emit        = 1'b1;
                                emit_status = fqs_pkg::ST_EMPTY;
                            end else begin
                                mem_re     = 1'b1;
                                n_scan_ptr = ptr_next(r_rd_ptr);
                                n_idx      = '0;
                                n_state    = fqs_pkg::BS_SHOW;
                            end
                        end
                        fqs_pkg::OP_CLEAR: begin
                            emit     = 1'b1;
                            n_rd_ptr = '0;
                            n_wr_ptr = '0;
                            n_occ    = '0;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            fqs_pkg::BS_POP: begin
                if (slot_free) begin
                    emit       = 1'b1;
                    emit_value = r_rd_data;
                    n_rd_ptr   = ptr_next(r_rd_ptr);
                    n_occ      = r_occ - CW'(1);
                    n_state    = fqs_pkg::BS_IDLE;
                end
            end
            fqs_pkg::BS_SEARCH: begin
                // one compare per cycle, oldest to newest
                n_hit = r_hit | (r_rd_data == r_probe);
                if (show_last) begin
                    n_state = fqs_pkg::BS_SRES;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = r_scan_ptr;
                    n_scan_ptr = ptr_next(r_scan_ptr);
                    n_idx      = r_idx + CW'(1);
                end
            end
            fqs_pkg::BS_SRES: begin
                if (slot_free) begin
                    emit       = 1'b1;
                    emit_found = r_hit;
                    n_state    = fqs_pkg::BS_IDLE;
                end
            end
            fqs_pkg::BS_SHOW: begin
                // one shown entry per cycle while the output drains
                if (slot_free) begin
                    emit       = 1'b1;
                    emit_value = r_rd_data;
                    emit_last  = show_last;
                    if (show_last) begin
                        n_state = fqs_pkg::BS_IDLE;
                    end else begin
                        mem_re     = 1'b1;
                        mem_raddr  = r_scan_ptr;
                        n_scan_ptr = ptr_next(r_scan_ptr);
                        n_idx      = r_idx + CW'(1);
                    end
                end
            end
            default: begin
                n_state = fqs_pkg::BS_IDLE;
            end
        endcase

        // output register load
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out       = '{status:   emit_status,
                            value:    emit_value,
                            found:    emit_found,
                            is_empty: (n_occ == '0),
                            count:    fqs_pkg::t_count'(n_occ),
                            last:     emit_last};
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fqs_pkg::BS_IDLE;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_scan_ptr <= n_scan_ptr;
        r_idx      <= n_idx;
        r_hit      <= n_hit;
        r_probe    <= n_probe;
        r_out      <= n_out;
    end

    // ring store write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr_ptr] <= i_cmd.operand;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    // result channel
    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out.status;
    assign o_res.result_value = r_out.value;
    assign o_res.found        = r_out.found;
    assign o_res.is_empty     = r_out.is_empty;
    assign o_res.entry_count  = r_out.count;
    assign o_res.last_result  = r_out.last;

    // pointer consistency: write pointer sits occupancy entries past read pointer
    logic [PW1-1:0] ptr_sum, ptr_wrap;
    assign ptr_sum  = {1'b0, r_rd_ptr} + PW1'(r_occ);
    assign ptr_wrap = (ptr_sum >= PW1'(DEPTH)) ? ptr_sum - PW1'(DEPTH) : ptr_sum;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(DEPTH))
        else $error("occupancy above depth");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ptr_wrap[PW-1:0] == r_wr_ptr)
        else $error("ring pointers disagree with occupancy");

    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_occ < CW'(DEPTH)))
        else $error("store written while full");

    a_partial_show: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last) |-> (r_state == fqs_pkg::BS_SHOW))
        else $error("non-final result outside a show run");

endmodule

`default_nettype wire

@@ rtl/fifo_queue_with_search.sv @@
// ============================================================================
// fifo_queue_with_search
// First-in first-out queue of signed 32-bit values with membership search.
// ============================================================================
//
//  channel   dir  handshake     payload
//  i_cmd     in   valid/ready   action, operand_value
//  o_res     out  valid/ready   status, result_value, found, is_empty,
//                               entry_count, last_result
//
//  A request is held in the command queue until the back engine takes it.
//  Push, clear and query then load their result when taken, pop after a store read.
//  Search reads one entry per cycle and loads its result after the last
//  compare; show emits one entry per cycle, unless the output stalls, after
//  reading the first entry. Both are set by the single read port of the ring store.
//  Reset is synchronous and empties the queue; store contents are kept.
//  A stalled result holds in the output register and the back engine waits;
//  the front keeps accepting until its two-entry queue fills.
//
`default_nettype none

module fifo_queue_with_search #(
    parameter int DEPTH = fqs_pkg::FQS_DEPTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    fqs_in_if.sink     i_cmd,
    fqs_out_if.source  o_res
);

    logic          cmd_valid;
    logic          cmd_take;
    fqs_pkg::t_cmd cmd;

    // request intake and classification
    fqs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    // execution on the ring store
    fqs_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

@@ test/tb_fifo_queue_with_search.sv @@
// ============================================================================
// tb_fifo_queue_with_search
// Self-checking testbench of the fifo queue with membership search.
// Sends push, pop, search, show, clear and query requests in random bursts.
// The result side stalls on a pattern of its own and once holds off long
// enough to fill the block. Every returned result is compared field by
// field with a behavioral copy of the queue.
// ============================================================================

module tb_fifo_queue_with_search;
    timeunit 1ns;
    timeprecision 1ps;

    import fqs_pkg::*;

    localparam int DEPTH          = FQS_DEPTH;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int RANDOM_ITEMS   = 200;
    localparam int LONG_HOLD      = 200;

    // action codes the block accepts and ignores
    localparam t_action ACT_SPARE6 = 3'd6;
    localparam t_action ACT_SPARE7 = 3'd7;

    typedef enum int {
        RX_ALWAYS,
        RX_PATTERN,
        RX_RANDOM
    } t_rx_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // clock generation
    always #2 i_clk = ~i_clk;

    fqs_in_if  cmd_if ();
    fqs_out_if res_if ();

    fifo_queue_with_search #(
        .DEPTH (DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_res   (res_if.source)
    );

    // behavioral copy of the queue
    t_data queue_store [DEPTH];
    int    queue_head  = 0;
    int    queue_tail  = 0;
    int    queue_fill  = 0;

    // results still owed by the block, oldest first
    t_res  pending_results [$];
    t_res  oldest_result;

    int    mismatch_count = 0;
    int    idle_cycles    = 0;

    // sender pacing
    bit    pace_enable = 1'b1;
    int    burst_left  = 0;

    // receiver stall control
    int       hold_request  = 0;
    int       hold_left     = 0;
    int       segment_left  = 0;
    t_rx_mode ready_mode    = RX_ALWAYS;
    logic [15:0] stall_pattern = 16'hffff;

    t_data value_pool [8] = '{
        32'sh7fffffff, 32'sh80000000, 32'sh00000000, -32'sd1,
        32'sh00000001, 32'sh55555555, 32'shaaaaaaaa, 32'sh12345678
    };

    // record one result, reporting the queue after the step
    function automatic void owe_result(t_status st, t_data value, logic hit, logic last);
        t_res r;
        r.status   = st;
        r.value    = value;
        r.found    = hit;
        r.is_empty = (queue_fill == 0);
        r.count    = t_count'(queue_fill);
        r.last     = last;
        pending_results.push_back(r);
    endfunction

    // apply one request to the queue copy and record its results
    function automatic void predict_queue_response(t_action act, t_data operand);
        int    p;
        logic  hit;
        t_data popped;
        case (act)
            ACT_PUSH: begin
                if (queue_fill >= DEPTH) begin
                    owe_result(ST_FULL, '0, 1'b0, 1'b1);
                end else begin
                    queue_store[queue_tail] = operand;
                    queue_tail = (queue_tail + 1) % DEPTH;
                    queue_fill++;
                    owe_result(ST_OK, '0, 1'b0, 1'b1);
                end
            end
            ACT_POP: begin
                if (queue_fill == 0) begin
                    owe_result(ST_EMPTY, '0, 1'b0, 1'b1);
                end else begin
                    popped = queue_store[queue_head];
                    queue_head = (queue_head + 1) % DEPTH;
                    queue_fill--;
                    owe_result(ST_OK, popped, 1'b0, 1'b1);
                end
            end
            ACT_SEARCH: begin
                hit = 1'b0;
                p   = queue_head;
                for (int i = 0; i < queue_fill; i++) begin
                    if (queue_store[p] == operand) hit = 1'b1;
                    p = (p + 1) % DEPTH;
                end
                owe_result(ST_OK, '0, hit, 1'b1);
            end
            ACT_SHOW: begin
                if (queue_fill == 0) begin
                    owe_result(ST_EMPTY, '0, 1'b0, 1'b1);
                end else begin
                    p = queue_head;
                    for (int i = 0; i < queue_fill; i++) begin
                        owe_result(ST_OK, queue_store[p], 1'b0, i == queue_fill - 1);
                        p = (p + 1) % DEPTH;
                    end
                end
            end
            ACT_CLEAR: begin
                queue_head = 0;
                queue_tail = 0;
                queue_fill = 0;
                owe_result(ST_OK, '0, 1'b0, 1'b1);
            end
            default: begin
                owe_result(ST_OK, '0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    // operand mix: pool values, extremes and full random words
    function automatic t_data pick_operand();
        case ($urandom_range(0, 9))
            0, 1, 2: return value_pool[$urandom_range(0, 7)];
            3:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return t_data'($urandom);
        endcase
    endfunction

    // search probe: when not empty, half the time a value that is stored right now
    function automatic t_data pick_probe();
        if (queue_fill > 0 && $urandom_range(0, 1) == 1)
            return queue_store[(queue_head + $urandom_range(0, queue_fill - 1)) % DEPTH];
        return pick_operand();
    endfunction

    // send one request and wait for its acceptance
    task automatic send_request(input t_action act, input t_data operand);
        @(negedge i_clk);
        cmd_if.valid         <= 1'b1;
        cmd_if.action        <= act;
        cmd_if.operand_value <= operand;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        predict_queue_response(act, operand);
        // bursts of random length with gaps between them
        if (pace_enable) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 12);
                @(negedge i_clk);
                cmd_if.valid <= 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge i_clk);
            end
        end
    endtask

    // extremes, every action and the empty cases from reset
    task automatic test_basic_commands();
        send_request(ACT_POP,    32'sh00000000);
        send_request(ACT_SHOW,   32'sh00000000);
        send_request(ACT_SEARCH, 32'sh00000000);
        send_request(ACT_QUERY,  32'sh00000000);
        send_request(ACT_SPARE6, -32'sd1);
        send_request(ACT_SPARE7, 32'sh5a5a5a5a);
        send_request(ACT_PUSH,   32'sh7fffffff);
        send_request(ACT_PUSH,   32'sh80000000);
        send_request(ACT_PUSH,   32'sh00000000);
        send_request(ACT_PUSH,   -32'sd1);
        send_request(ACT_SEARCH, 32'sh80000000);
        send_request(ACT_SEARCH, 32'sh00000001);
        send_request(ACT_SHOW,   32'shffff0000);
        send_request(ACT_QUERY,  -32'sd1);
        send_request(ACT_POP,    32'sh0000ffff);
        send_request(ACT_SEARCH, 32'sh7fffffff);
        send_request(ACT_CLEAR,  32'sh7fffffff);
        send_request(ACT_QUERY,  32'sh80000000);
        send_request(ACT_POP,    32'sh00000000);
        send_request(ACT_SHOW,   32'sh00000000);
    endtask

    // fill to the top while results are held off, then wrap the ring
    task automatic test_fill_under_backpressure();
        pace_enable = 1'b0;
        send_request(ACT_CLEAR, pick_operand());
        hold_request = LONG_HOLD;
        for (int i = 0; i <= DEPTH; i++)
            send_request(ACT_PUSH, (i == 0) ? 32'sh80000000 : pick_operand());
        send_request(ACT_SEARCH, queue_store[(queue_head + DEPTH - 1) % DEPTH]);
        send_request(ACT_SEARCH, pick_operand());
        send_request(ACT_SHOW,   32'sh00000000);
        send_request(ACT_POP,    32'sh00000000);
        send_request(ACT_PUSH,   32'sh7fffffff);
        send_request(ACT_SHOW,   -32'sd1);
        send_request(ACT_SEARCH, 32'sh7fffffff);
        pace_enable = 1'b1;
    endtask

    // random traffic in fill, drain and mixed phases
    task automatic test_random_traffic();
        int      sent;
        int      phase_left;
        int      push_weight;
        int      pop_weight;
        int      roll;
        t_action act;
        t_data   operand;
        sent       = 0;
        phase_left = 0;
        push_weight = 35;
        pop_weight  = 30;
        while (sent < RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(15, 40);
                case ($urandom_range(0, 2))
                    0: begin push_weight = 65; pop_weight = 10; end
                    1: begin push_weight = 15; pop_weight = 55; end
                    default: begin push_weight = 35; pop_weight = 30; end
                endcase
                pace_enable = ($urandom_range(0, 3) != 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < push_weight) begin
                act = ACT_PUSH;
            end else if (roll < push_weight + pop_weight) begin
                act = ACT_POP;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 40)      act = ACT_SEARCH;
                else if (roll < 65) act = ACT_SHOW;
                else if (roll < 77) act = ACT_QUERY;
                else if (roll < 85) act = ACT_CLEAR;
                else                act = roll[0] ? ACT_SPARE6 : ACT_SPARE7;
            end
            operand = (act == ACT_SEARCH) ? pick_probe() : pick_operand();
            send_request(act, operand);
            if (act != ACT_SPARE6 && act != ACT_SPARE7) sent++;
            phase_left--;
        end
        pace_enable = 1'b1;
    endtask

    // drop valid and let every owed result come back
    task automatic wait_for_results();
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // result side stalls: long hold on request, else pattern segments
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else begin
            if (segment_left == 0) begin
                segment_left  = $urandom_range(10, 60);
                ready_mode    = t_rx_mode'($urandom_range(0, 2));
                stall_pattern = 16'($urandom);
            end
            segment_left--;
            case (ready_mode)
                RX_ALWAYS: res_if.ready <= 1'b1;
                RX_PATTERN: begin
                    res_if.ready  <= stall_pattern[0];
                    stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
                end
                default: res_if.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    function automatic void check_field(string name, logic signed [32:0] want,
                                        logic signed [32:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // compare each accepted result with the oldest one owed
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d value %0d",
                       res_if.status, res_if.result_value);
                mismatch_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                check_field("status",       oldest_result.status,   res_if.status);
                check_field("result_value", oldest_result.value,    res_if.result_value);
                check_field("found",        oldest_result.found,    res_if.found);
                check_field("is_empty",     oldest_result.is_empty, res_if.is_empty);
                check_field("entry_count",  oldest_result.count,    res_if.entry_count);
                check_field("last_result",  oldest_result.last,     res_if.last_result);
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) ||
            (res_if.valid === 1'b1 && res_if.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL fifo_queue_with_search");
            $finish;
        end
    end

    // test sequence
    initial begin
        cmd_if.valid         = 1'b0;
        cmd_if.action        = ACT_QUERY;
        cmd_if.operand_value = '0;
        res_if.ready         = 1'b1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_commands();
        test_fill_under_backpressure();
        test_random_traffic();
        wait_for_results();

        if (mismatch_count == 0)
            $display("PASS fifo_queue_with_search");
        else
            $display("FAIL fifo_queue_with_search");
        $finish;
    end

endmodule
